>>> rtl/core/rfrg_pkg.sv
// ----------------------------------------------------------------------------
// rfrg_pkg
// shared types and constants for the radar frame range gate
// ----------------------------------------------------------------------------
package rfrg_pkg;

	localparam int unsigned PAYLOAD_BYTES_DEF = 8;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned LIMIT_W = 2 * DIST_W;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] HDR_SYNC = 8'hAA;
	localparam logic [DATA_W-1:0] HDR_ID1 = 8'h0C;
	localparam logic [DATA_W-1:0] HDR_ID2 = 8'h07;
	localparam logic [DATA_W-1:0] TRL_SYNC = 8'h55;

	localparam logic [DIST_W-1:0] RST_STEP = 16'd10;
	localparam logic [DIST_W-1:0] RST_MIN = 16'd10;
	localparam logic [DIST_W-1:0] RST_MAX = 16'd2000;
	localparam logic [DIST_W-1:0] RST_GOOD = 16'd20;
	localparam logic [DIST_W-1:0] MISS_ONE = 16'd1;
	localparam logic [DIST_W-1:0] MISS_SAT = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_STEP = 2'd0,
		REG_MIN_VALID = 2'd1,
		REG_MAX_VALID = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_HUNT = 3'd0,
		ST_SYNC2 = 3'd1,
		ST_ID1 = 3'd2,
		ST_ID2 = 3'd3,
		ST_PAYLOAD = 3'd4,
		ST_TRL1 = 3'd5,
		ST_TRL2 = 3'd6
	} frame_state_t;

endpackage

>>> rtl/core/radar_frame_range_gate_unit.sv
// ----------------------------------------------------------------------------
// radar_frame_range_gate_unit
// frame parser for a serial radar link with distance gating
//
//   channel | dir | handshake           | word
//   in      | in  | in_valid/in_stall   | rx_byte
//   out     | out | out_valid/out_stall | distance_cm, raw_distance_cm,
//           |     |                     | held, out_of_range, misses
//   cfg     | in  | cfg_wr_en           | cfg_index, cfg_data
//
// one byte per cycle unless stalled; the parser updates on the accepting edge
// the edge that takes the last trailer byte also loads the result register,
// so the result word is valid in the next cycle
// in_stall rises only on the last trailer byte while a result still waits
// reset restores the register defaults, the hunt state, last good 20, misses 1
// ----------------------------------------------------------------------------
module radar_frame_range_gate_unit #(
	parameter int unsigned PAYLOAD_BYTES = rfrg_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rfrg_pkg::DATA_W-1:0]    rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rfrg_pkg::DIST_W-1:0]    distance_cm,
	output logic [rfrg_pkg::DIST_W-1:0]    raw_distance_cm,
	output logic                           held,
	output logic                           out_of_range,
	output logic [rfrg_pkg::DIST_W-1:0]    misses,
	input  logic                           cfg_wr_en,
	input  logic [rfrg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfrg_pkg::DIST_W-1:0]    cfg_data
);
	import rfrg_pkg::*;

	localparam int unsigned PIDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(PAYLOAD_BYTES - 1);
	localparam logic [PIDX_W-1:0] PIDX_HI = PIDX_W'(2);
	localparam logic [PIDX_W-1:0] PIDX_LO = PIDX_W'(3);

	frame_state_t state_q, state_d;
	logic [PIDX_W-1:0] pidx_q, pidx_d;
	logic [DATA_W-1:0] hi_q, lo_q;
	logic [DIST_W-1:0] max_step_q, min_valid_q, max_valid_q;
	logic [DIST_W-1:0] last_good_q, miss_count_q;
	logic in_accept, out_accept, frame_done;

	logic [DIST_W-1:0] raw_c, diff_c;
	logic [LIMIT_W-1:0] limit_c;
	logic oor_c, held_c;
	logic [DIST_W-1:0] miss_inc;

	logic out_valid_q, held_q, oor_q;
	logic [DIST_W-1:0] dist_q, raw_q, misses_q;

	assign in_stall = out_valid_q && (state_q == ST_TRL2);
	assign in_accept = in_valid && !in_stall;
	assign out_accept = out_valid_q && !out_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= RST_STEP;
			min_valid_q <= RST_MIN;
			max_valid_q <= RST_MAX;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_STEP: max_step_q <= cfg_data;
				REG_MIN_VALID: min_valid_q <= cfg_data;
				REG_MAX_VALID: max_valid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			pidx_q <= '0;
		end else begin
			state_q <= state_d;
			pidx_q <= pidx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pidx_d = pidx_q;
		frame_done = 1'b0;
		if (in_accept) begin
			unique case (state_q)
				ST_HUNT: state_d = (rx_byte == HDR_SYNC) ? ST_SYNC2 : ST_HUNT;
				ST_SYNC2: state_d = (rx_byte == HDR_SYNC) ? ST_ID1 : ST_HUNT;
				ST_ID1: state_d = (rx_byte == HDR_ID1) ? ST_ID2 : ST_HUNT;
				ST_ID2: begin
					if (rx_byte == HDR_ID2) begin
						state_d = ST_PAYLOAD;
						pidx_d = '0;
					end else begin
						state_d = ST_HUNT;
					end
				end
				ST_PAYLOAD: begin
					if (pidx_q == PIDX_LAST) begin
						pidx_d = '0;
						state_d = ST_TRL1;
					end else begin
						pidx_d = pidx_q + PIDX_W'(1);
					end
				end
				ST_TRL1: state_d = (rx_byte == TRL_SYNC) ? ST_TRL2 : ST_HUNT;
				ST_TRL2: begin
					state_d = ST_HUNT;
					frame_done = (rx_byte == TRL_SYNC);
				end
				default: state_d = ST_HUNT;
			endcase
		end
	end

	// distance bytes of the payload
	always_ff @(posedge clk) begin
		if (in_accept && state_q == ST_PAYLOAD) begin
			if (pidx_q == PIDX_HI) begin
				hi_q <= rx_byte;
			end
			if (pidx_q == PIDX_LO) begin
				lo_q <= rx_byte;
			end
		end
	end

	// range test, step size and allowed jump
	assign raw_c = {hi_q, lo_q};
	assign oor_c = (raw_c <= min_valid_q) || (raw_c >= max_valid_q);
	assign diff_c = (raw_c >= last_good_q) ? raw_c - last_good_q : last_good_q - raw_c;
	assign limit_c = LIMIT_W'(miss_count_q) * LIMIT_W'(max_step_q);

	// gate decision
	assign held_c = oor_c || (LIMIT_W'(diff_c) >= limit_c);
	assign miss_inc = (miss_count_q == MISS_SAT) ? miss_count_q : miss_count_q + MISS_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_good_q <= RST_GOOD;
			miss_count_q <= MISS_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (frame_done) begin
				out_valid_q <= 1'b1;
				if (held_c) begin
					miss_count_q <= miss_inc;
				end else begin
					last_good_q <= raw_c;
					miss_count_q <= MISS_ONE;
				end
			end else if (out_accept) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			dist_q <= held_c ? last_good_q : raw_c;
			raw_q <= raw_c;
			held_q <= held_c;
			oor_q <= oor_c;
			misses_q <= held_c ? miss_inc : MISS_ONE;
		end
	end

	assign out_valid = out_valid_q;
	assign distance_cm = dist_q;
	assign raw_distance_cm = raw_q;
	assign held = held_q;
	assign out_of_range = oor_q;
	assign misses = misses_q;

endmodule

>>> rtl/core/rfrg_checker.sv
// ----------------------------------------------------------------------------
// rfrg_checker
// port-level checks for the radar frame range gate
// ----------------------------------------------------------------------------
module rfrg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [rfrg_pkg::DIST_W-1:0] distance_cm,
	input logic [rfrg_pkg::DIST_W-1:0] raw_distance_cm,
	input logic                        held,
	input logic                        out_of_range,
	input logic [rfrg_pkg::DIST_W-1:0] misses
);
	import rfrg_pkg::*;

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_cm) && $stable(misses))
		else $error("output word changed while stalled");

	// accepted word passes the raw distance through
	a_pass_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !held |-> distance_cm == raw_distance_cm)
		else $error("accepted distance differs from raw distance");

	// accepted word resets the miss count
	a_pass_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !held |-> misses == MISS_ONE)
		else $error("miss count not reset on accepted distance");

	// out of range always holds, and a hold always counts a miss
	a_oor_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> held && misses != MISS_ONE)
		else $error("out of range word not held");

endmodule

bind radar_frame_range_gate_unit rfrg_checker u_rfrg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.distance_cm(distance_cm),
	.raw_distance_cm(raw_distance_cm),
	.held(held),
	.out_of_range(out_of_range),
	.misses(misses)
);
